// File: hw/rtl/wcc_pkg.sv
`default_nettype none
package wcc_pkg;

  localparam int HUE_BITS      = 9;
  localparam int SCALE_BITS    = 16;
  localparam int COLOR_BITS    = 8;
  localparam int EXTENT_BITS   = 16;
  localparam int QUOT_BITS     = 8;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_HUE     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT_SCALE = 2'd1;

  localparam logic [SCALE_BITS-1:0] HEIGHT_SCALE_RESET = 16'd256;
  localparam logic [HUE_BITS-1:0]   HUE_FULL           = 9'd360;

  // Channel scaling: units of 1/(255*255*60) back to 0..255
  localparam int FULL_SCALE  = 255;
  localparam int SECTOR_SPAN = 60;
  localparam int TO8_DIV     = 30600;
  localparam int TO8_BIAS    = 15300;

  // Divide by TO8_DIV as (n >> 3) / 3825, done by reciprocal multiply
  localparam int TO8_PRE_SHIFT  = 3;
  localparam int TO8_RECIP_BITS = 21;
  localparam logic [TO8_RECIP_BITS-1:0] TO8_RECIP = 21'd1122868;  // ceil(2^32 / 3825)
  localparam int TO8_POST_SHIFT = 32;

  // Sector of a hue in 0..359
  function automatic logic [2:0] hue_sector(input logic [HUE_BITS-1:0] h);
    logic [2:0] s;
    if (h < 9'd60) s = 3'd0;
    else if (h < 9'd120) s = 3'd1;
    else if (h < 9'd180) s = 3'd2;
    else if (h < 9'd240) s = 3'd3;
    else if (h < 9'd300) s = 3'd4;
    else s = 3'd5;
    return s;
  endfunction

  function automatic logic [HUE_BITS-1:0] sector_base(input logic [2:0] s);
    logic [HUE_BITS-1:0] b;
    case (s)
      3'd0: b = 9'd0;
      3'd1: b = 9'd60;
      3'd2: b = 9'd120;
      3'd3: b = 9'd180;
      3'd4: b = 9'd240;
      default: b = 9'd300;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/wcc_frame_if.sv
`default_nettype none
interface wcc_frame_if #(parameter int LEVEL_BITS = 8);
  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] low_left;
  logic [LEVEL_BITS-1:0] mid_left;
  logic [LEVEL_BITS-1:0] high_left;
  logic [LEVEL_BITS-1:0] all_left;
  logic [LEVEL_BITS-1:0] low_right;
  logic [LEVEL_BITS-1:0] mid_right;
  logic [LEVEL_BITS-1:0] high_right;
  logic [LEVEL_BITS-1:0] all_right;
  logic                  column_end;

  modport source (output valid, low_left, mid_left, high_left, all_left, low_right,
                  mid_right, high_right, all_right, column_end, input ready);
  modport sink (input valid, low_left, mid_left, high_left, all_left, low_right,
                mid_right, high_right, all_right, column_end, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/wcc_column_if.sv
`default_nettype none
interface wcc_column_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [15:0] upper_extent;
  logic [15:0] lower_extent;

  modport source (output valid, red, green, blue, upper_extent, lower_extent, input ready);
  modport sink (input valid, red, green, blue, upper_extent, lower_extent, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/wcc_lane.sv
`default_nettype none
module wcc_lane #(
  parameter int LB = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic          column_end,
  input  wire logic [LB-1:0] low,
  input  wire logic [LB-1:0] mid,
  input  wire logic [LB-1:0] high,
  input  wire logic [LB-1:0] all,
  output logic      [LB-1:0] peak_low_next,
  output logic      [LB-1:0] peak_mid_next,
  output logic      [LB-1:0] peak_high_next,
  output logic      [LB-1:0] peak_all_next
);

  logic [LB-1:0] peak_low, peak_mid, peak_high, peak_all;

  // Maxima including the frame on the bus
  assign peak_low_next  = (low  > peak_low)  ? low  : peak_low;
  assign peak_mid_next  = (mid  > peak_mid)  ? mid  : peak_mid;
  assign peak_high_next = (high > peak_high) ? high : peak_high;
  assign peak_all_next  = (all  > peak_all)  ? all  : peak_all;

  always_ff @(posedge clk) begin
    if (rst || (accept && column_end)) begin
      peak_low  <= '0;
      peak_mid  <= '0;
      peak_high <= '0;
      peak_all  <= '0;
    end else if (accept) begin
      peak_low  <= peak_low_next;
      peak_mid  <= peak_mid_next;
      peak_high <= peak_high_next;
      peak_all  <= peak_all_next;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/wcc_div.sv
`default_nettype none
module wcc_div
  import wcc_pkg::*;
#(
  parameter int NW = 24,
  parameter int MW = 15
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [NW-1:0]        num,
  input  wire logic [MW-1:0]        den,
  output logic                      done,
  output logic      [QUOT_BITS-1:0] quot
);

  // Quotient is known to fit QUOT_BITS: one restoring step per cycle
  logic          busy;
  logic [2:0]    cnt;
  logic [NW-1:0] rem;
  logic [NW-1:0] dsr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'(QUOT_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dsr  <= NW'({den, {(QUOT_BITS-1){1'b0}}});
      quot <= '0;
    end else if (busy) begin
      if (rem >= dsr) begin
        rem  <= rem - dsr;
        quot <= {quot[QUOT_BITS-2:0], 1'b1};
      end else begin
        quot <= {quot[QUOT_BITS-2:0], 1'b0};
      end
      dsr <= dsr >> 1;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/wcc_merge.sv
`default_nettype none
module wcc_merge
  import wcc_pkg::*;
#(
  parameter int LB = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  capture,
  input  wire logic [LB-1:0]         low_l,
  input  wire logic [LB-1:0]         mid_l,
  input  wire logic [LB-1:0]         high_l,
  input  wire logic [LB-1:0]         all_l,
  input  wire logic [LB-1:0]         low_r,
  input  wire logic [LB-1:0]         mid_r,
  input  wire logic [LB-1:0]         high_r,
  input  wire logic [LB-1:0]         all_r,
  input  wire logic [HUE_BITS-1:0]   base_hue,
  input  wire logic [SCALE_BITS-1:0] height_scale,
  output logic                       idle,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [COLOR_BITS-1:0]      red,
  output logic [COLOR_BITS-1:0]      green,
  output logic [COLOR_BITS-1:0]      blue,
  output logic [EXTENT_BITS-1:0]     upper,
  output logic [EXTENT_BITS-1:0]     lower
);

  localparam int NW = (LB + 16 > 24) ? LB + 16 : 24;
  localparam int MW = (LB + 7 > 15) ? LB + 7 : 15;
  localparam int SW = LB + 3;
  localparam int UW = 22;
  localparam int PW = LB + SCALE_BITS;
  localparam int NQ = UW + 1 - TO8_PRE_SHIFT;
  localparam int RPW = NQ + TO8_RECIP_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_DIV_S = 4'd2;
  localparam logic [3:0] S_DIV_V = 4'd3;
  localparam logic [3:0] S_MUL1  = 4'd4;
  localparam logic [3:0] S_MUL2  = 4'd5;
  localparam logic [3:0] S_CONV  = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;

  // round(u / (255*255*60) * 255): (2u + bias) / 30600 by reciprocal multiply
  function automatic logic [COLOR_BITS-1:0] to8(input logic [UW-1:0] u);
    logic [UW:0]    n;
    logic [NQ-1:0]  nq;
    logic [RPW-1:0] p;
    n  = {u, 1'b0} + (UW+1)'(TO8_BIAS);
    nq = n[UW:TO8_PRE_SHIFT];
    p  = RPW'(nq) * RPW'(TO8_RECIP);
    return p[TO8_POST_SHIFT +: COLOR_BITS];
  endfunction

  logic [3:0] state;

  logic [LB-1:0] pl_low, pl_mid, pl_high, pl_all, pr_low, pr_mid, pr_high, pr_all;

  logic [SW-1:0]   dsum;
  logic [LB:0]     hsum, lsum;
  logic            silent;
  logic [NW-1:0]   den6, num_s, num_v;
  logic [NW-1:0]   num_v_hold;
  logic [MW-1:0]   den2, den2_hold;
  logic [PW-1:0]   prod_u, prod_l;

  logic [COLOR_BITS-1:0] sat, val;
  logic [15:0]           vs;

  logic [HUE_BITS-1:0] hue;
  logic [2:0]          sector;
  logic [5:0]          frac, fx;
  logic [UW-1:0]       cc, xx, mm;
  logic [UW-1:0]       ur, ug, ub;
  logic [UW-1:0]       ur_hold, ug_hold, ub_hold;

  logic                 div_start, div_done;
  logic [NW-1:0]        div_num;
  logic [MW-1:0]        div_den;
  logic [QUOT_BITS-1:0] div_quot;

  assign idle = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // Column sums and exact numerators for s and v
  always_comb begin
    dsum   = SW'(pl_low) + SW'(pr_low) + SW'(pl_mid) + SW'(pr_mid) + SW'(pl_high)
           + SW'(pr_high);
    hsum   = (LB+1)'(pl_high) + (LB+1)'(pr_high);
    lsum   = (LB+1)'(pl_low) + (LB+1)'(pr_low);
    silent = (pl_all == '0) || (pr_all == '0) || (dsum == '0);
    den6   = NW'(dsum) * NW'(6);
    num_s  = ((NW'(FULL_SCALE) * (den6 - NW'(5) * NW'(hsum))) << 1) + den6;
    num_v  = ((NW'(FULL_SCALE) * (den6 - NW'(5) * NW'(lsum))) << 1) + den6;
    den2   = MW'(den6 << 1);
    prod_u = PW'(pl_all) * PW'(height_scale);
    prod_l = PW'(pr_all) * PW'(height_scale);
  end

  // Hue sector and channel terms
  always_comb begin
    hue    = (base_hue >= HUE_FULL) ? base_hue - HUE_FULL : base_hue;
    sector = hue_sector(hue);
    frac   = 6'(hue - sector_base(sector));
    fx     = sector[0] ? 6'(SECTOR_SPAN) - frac : frac;
    cc     = UW'(vs) * UW'(SECTOR_SPAN);
    xx     = UW'(vs) * UW'(fx);
    mm     = UW'(val) * UW'(FULL_SCALE * SECTOR_SPAN) - cc;
    ur     = mm;
    ug     = mm;
    ub     = mm;
    case (sector)
      3'd0: begin ur = cc + mm; ug = xx + mm; end
      3'd1: begin ur = xx + mm; ug = cc + mm; end
      3'd2: begin ug = cc + mm; ub = xx + mm; end
      3'd3: begin ug = xx + mm; ub = cc + mm; end
      3'd4: begin ur = xx + mm; ub = cc + mm; end
      default: begin ur = cc + mm; ub = xx + mm; end
    endcase
  end

  // Divider request select
  always_comb begin
    div_start = 1'b0;
    div_num   = num_s;
    div_den   = den2;
    case (state)
      S_PREP: div_start = !silent;
      S_DIV_S: begin
        div_start = div_done;
        div_num   = num_v_hold;
        div_den   = den2_hold;
      end
      default: div_start = 1'b0;
    endcase
  end

  wcc_div #(.NW(NW), .MW(MW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:  if (capture) state <= S_PREP;
        S_PREP:  state <= silent ? S_MUL1 : S_DIV_S;
        S_DIV_S: if (div_done) state <= S_DIV_V;
        S_DIV_V: if (div_done) state <= S_MUL1;
        S_MUL1:  state <= S_MUL2;
        S_MUL2:  state <= S_CONV;
        S_CONV:  state <= S_OUT;
        S_OUT:   if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && capture) begin
      pl_low <= low_l;  pl_mid <= mid_l;  pl_high <= high_l;  pl_all <= all_l;
      pr_low <= low_r;  pr_mid <= mid_r;  pr_high <= high_r;  pr_all <= all_r;
    end
    if (state == S_PREP) begin
      num_v_hold <= num_v;
      den2_hold  <= den2;
      upper <= (prod_u > PW'({EXTENT_BITS{1'b1}})) ? {EXTENT_BITS{1'b1}}
                                                   : EXTENT_BITS'(prod_u);
      lower <= (prod_l > PW'({EXTENT_BITS{1'b1}})) ? {EXTENT_BITS{1'b1}}
                                                   : EXTENT_BITS'(prod_l);
      if (silent) begin
        sat <= {COLOR_BITS{1'b1}};
        val <= {COLOR_BITS{1'b1}};
      end
    end
    if (state == S_DIV_S && div_done) sat <= div_quot;
    if (state == S_DIV_V && div_done) val <= div_quot;
    if (state == S_MUL1) vs <= 16'(val) * 16'(sat);
    if (state == S_MUL2) begin
      ur_hold <= ur;
      ug_hold <= ug;
      ub_hold <= ub;
    end
    if (state == S_CONV) begin
      red   <= to8(ur_hold);
      green <= to8(ug_hold);
      blue  <= to8(ub_hold);
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/waveform_column_hsv_color_unit.sv
// Waveform column colorizer. Each frame request carries low/mid/high/all levels for the
// left and right channel; two channel lanes keep running maxima over one display column.
// A frame without column_end is taken whenever the block is idle. A frame with column_end
// closes the column: the merge stage computes saturation and value (two runs of an 8-step
// divider, skipped for a silent column), converts hue/saturation/value to RGB with a
// reciprocal multiply and scales the all-band maxima into saturated Q8.8 bar extents. The
// column result is registered through the PREP, divider, MUL1, MUL2 and CONV states and
// held valid in OUT; the block takes no new frame until that column request has been
// taken at the output. Configuration (base_hue, height_scale) is written through
// cfg_write/cfg_index/cfg_data; the user must write it only while the block is idle, and
// the block itself does not enforce this.
`default_nettype none
module waveform_column_hsv_color_unit
  import wcc_pkg::*;
#(
  parameter int LEVEL_BITS = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  wcc_frame_if.sink                     frame,
  wcc_column_if.source                  column
);

  logic [HUE_BITS-1:0]   base_hue;
  logic [SCALE_BITS-1:0] height_scale;

  logic accept;
  logic merge_idle;

  logic [LEVEL_BITS-1:0] l_low, l_mid, l_high, l_all;
  logic [LEVEL_BITS-1:0] r_low, r_mid, r_high, r_all;

  // Hold off new frames while a column is in the merge stage or waiting at the output
  assign frame.ready = merge_idle;
  assign accept = frame.valid && frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_hue     <= '0;
      height_scale <= HEIGHT_SCALE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BASE_HUE:     base_hue     <= cfg_data[HUE_BITS-1:0];
        CFG_HEIGHT_SCALE: height_scale <= cfg_data[SCALE_BITS-1:0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // Left channel lane
  wcc_lane #(.LB(LEVEL_BITS)) u_lane_l (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .column_end     (frame.column_end),
    .low            (frame.low_left),
    .mid            (frame.mid_left),
    .high           (frame.high_left),
    .all            (frame.all_left),
    .peak_low_next  (l_low),
    .peak_mid_next  (l_mid),
    .peak_high_next (l_high),
    .peak_all_next  (l_all)
  );

  // Right channel lane
  wcc_lane #(.LB(LEVEL_BITS)) u_lane_r (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .column_end     (frame.column_end),
    .low            (frame.low_right),
    .mid            (frame.mid_right),
    .high           (frame.high_right),
    .all            (frame.all_right),
    .peak_low_next  (r_low),
    .peak_mid_next  (r_mid),
    .peak_high_next (r_high),
    .peak_all_next  (r_all)
  );

  // Merge the lane maxima into the column result
  wcc_merge #(.LB(LEVEL_BITS)) u_merge (
    .clk          (clk),
    .rst          (rst),
    .capture      (accept && frame.column_end),
    .low_l        (l_low),
    .mid_l        (l_mid),
    .high_l       (l_high),
    .all_l        (l_all),
    .low_r        (r_low),
    .mid_r        (r_mid),
    .high_r       (r_high),
    .all_r        (r_all),
    .base_hue     (base_hue),
    .height_scale (height_scale),
    .idle         (merge_idle),
    .out_valid    (column.valid),
    .out_ready    (column.ready),
    .red          (column.red),
    .green        (column.green),
    .blue         (column.blue),
    .upper        (column.upper_extent),
    .lower        (column.lower_extent)
  );

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top
  import wcc_pkg::*;
;

  localparam int CLOSE_LATENCY = 80;       // one closing column plus margin
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_FRAMES = 1250;
  localparam int LONG_STALL    = 400;

  // Register indexes the block does not implement
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNKNOWN_A = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNKNOWN_B = 2'd3;

  typedef struct packed {
    logic [7:0] low_l, mid_l, high_l, all_l;
    logic [7:0] low_r, mid_r, high_r, all_r;
    logic       col_end;
  } frame_t;

  typedef struct packed {
    logic [7:0]  red, green, blue;
    logic [15:0] upper, lower;
  } column_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  wcc_frame_if #(.LEVEL_BITS(8)) frame_bus ();
  wcc_column_if column_bus ();

  waveform_column_hsv_color_unit #(.LEVEL_BITS(8)) DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .frame(frame_bus), .column(column_bus)
  );

  always #4 clk = ~clk;

  // Frames waiting to be driven, and the columns they are predicted to produce
  frame_t  frame_pending[$];
  column_t column_expected[$];

  // Shadow of the block's configuration and running peaks
  logic [HUE_BITS-1:0]   hue_shadow = '0;
  logic [SCALE_BITS-1:0] scale_shadow = HEIGHT_SCALE_RESET;
  logic [7:0] pk_low_l, pk_mid_l, pk_high_l, pk_all_l;
  logic [7:0] pk_low_r, pk_mid_r, pk_high_r, pk_all_r;

  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit quiet = 1'b0;            // no idling in the final stretch
  bit long_stall_req = 1'b0;   // ask the receiver for one long hold-off

  // round(255*(6d - 5part)/(6d)), ties up
  function automatic longint unsigned unit_minus(longint unsigned part, longint unsigned d);
    longint unsigned den, num;
    den = 6 * d;
    num = 255 * (den - 5 * part);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic logic [15:0] scale_extent(logic [7:0] level);
    longint unsigned p;
    p = longint'(level) * longint'(scale_shadow);
    return (p > 65535) ? 16'hFFFF : p[15:0];
  endfunction

  function automatic logic [7:0] chan8(longint unsigned u);
    longint unsigned q;
    q = (2 * u + TO8_BIAS) / TO8_DIV;
    return q[7:0];
  endfunction

  // Close the column from the current peaks
  function automatic column_t predict_column();
    column_t col;
    longint unsigned d, s8, v8, c, x, m, r, g, b, h, sector, f;
    d = pk_low_l + pk_low_r + pk_mid_l + pk_mid_r + pk_high_l + pk_high_r;
    if (pk_all_l == 0 || pk_all_r == 0 || d == 0) begin
      s8 = 255;
      v8 = 255;
    end else begin
      s8 = unit_minus(pk_high_l + pk_high_r, d);
      v8 = unit_minus(pk_low_l + pk_low_r, d);
    end
    h = hue_shadow % HUE_FULL;
    sector = h / SECTOR_SPAN;
    f = h % SECTOR_SPAN;
    c = v8 * s8 * SECTOR_SPAN;
    x = sector[0] ? v8 * s8 * (SECTOR_SPAN - f) : v8 * s8 * f;
    m = v8 * FULL_SCALE * SECTOR_SPAN - c;
    r = 0; g = 0; b = 0;
    case (sector)
      0: begin r = c; g = x; end
      1: begin r = x; g = c; end
      2: begin g = c; b = x; end
      3: begin g = x; b = c; end
      4: begin r = x; b = c; end
      default: begin r = c; b = x; end
    endcase
    col.red   = chan8(r + m);
    col.green = chan8(g + m);
    col.blue  = chan8(b + m);
    col.upper = scale_extent(pk_all_l);
    col.lower = scale_extent(pk_all_r);
    return col;
  endfunction

  function automatic logic [7:0] max8(logic [7:0] a, logic [7:0] b);
    return (a > b) ? a : b;
  endfunction

  // Queue one frame and advance the shadow peaks
  task automatic queue_frame(frame_t fr);
    pk_low_l  = max8(pk_low_l, fr.low_l);
    pk_mid_l  = max8(pk_mid_l, fr.mid_l);
    pk_high_l = max8(pk_high_l, fr.high_l);
    pk_all_l  = max8(pk_all_l, fr.all_l);
    pk_low_r  = max8(pk_low_r, fr.low_r);
    pk_mid_r  = max8(pk_mid_r, fr.mid_r);
    pk_high_r = max8(pk_high_r, fr.high_r);
    pk_all_r  = max8(pk_all_r, fr.all_r);
    frame_pending.push_back(fr);
    if (fr.col_end) begin
      column_expected.push_back(predict_column());
      {pk_low_l, pk_mid_l, pk_high_l, pk_all_l} = '0;
      {pk_low_r, pk_mid_r, pk_high_r, pk_all_r} = '0;
    end
  endtask

  function automatic frame_t make_frame(logic [7:0] lvl, logic [7:0] all_l,
                                        logic [7:0] all_r, bit ce);
    frame_t fr;
    fr = '{lvl, lvl, lvl, all_l, lvl, lvl, lvl, all_r, ce};
    return fr;
  endfunction

  // Random levels: mostly full range, some tiny values, zeros and near-maximum values
  function automatic logic [7:0] rand_level();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 8'($urandom_range(0, 255));
    if (sel < 8) return 8'($urandom_range(0, 3));
    if (sel < 9) return 8'd0;
    return 8'($urandom_range(240, 255));
  endfunction

  function automatic frame_t rand_frame(bit ce);
    frame_t fr;
    fr.low_l = rand_level();  fr.mid_l = rand_level();
    fr.high_l = rand_level(); fr.all_l = rand_level();
    fr.low_r = rand_level();  fr.mid_r = rand_level();
    fr.high_r = rand_level(); fr.all_r = rand_level();
    fr.col_end = ce;
    return fr;
  endfunction

  // Hold until the block has drained, then let a closing column finish
  task automatic drain();
    while (frame_pending.size() != 0 || column_expected.size() != 0) @(posedge clk);
    repeat (CLOSE_LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_BASE_HUE) hue_shadow = val[HUE_BITS-1:0];
    else if (idx == CFG_HEIGHT_SCALE) scale_shadow = val;
  endtask

  // Well-formed columns of random length, with an occasional lone closing frame
  task automatic random_columns(int unsigned frames);
    int unsigned sent, len;
    sent = 0;
    while (sent < frames) begin
      len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
      for (int unsigned k = 0; k < len; k++) queue_frame(rand_frame(k == len - 1));
      sent += len;
      while (frame_pending.size() > 16) @(posedge clk);
    end
  endtask

  // Sender: present the oldest pending frame, hold it until taken
  int unsigned send_gap = 0;
  always @(posedge clk) begin
    bit taken;
    if (rst) begin
      frame_bus.valid <= 1'b0;
    end else begin
      taken = frame_bus.valid && frame_bus.ready;
      if (taken) begin
        void'(frame_pending.pop_front());
        if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 11);
      end
      if (frame_bus.valid && !taken) begin
        // hold the current request
      end else if (send_gap > 0) begin
        send_gap--;
        frame_bus.valid <= 1'b0;
      end else if (frame_pending.size() != 0) begin
        frame_bus.valid      <= 1'b1;
        frame_bus.low_left   <= frame_pending[0].low_l;
        frame_bus.mid_left   <= frame_pending[0].mid_l;
        frame_bus.high_left  <= frame_pending[0].high_l;
        frame_bus.all_left   <= frame_pending[0].all_l;
        frame_bus.low_right  <= frame_pending[0].low_r;
        frame_bus.mid_right  <= frame_pending[0].mid_r;
        frame_bus.high_right <= frame_pending[0].high_r;
        frame_bus.all_right  <= frame_pending[0].all_r;
        frame_bus.column_end <= frame_pending[0].col_end;
      end else begin
        frame_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, one long hold-off on request, and checking
  int unsigned recv_gap = 0;
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    column_t got, want;
    if (!rst && column_bus.valid && column_bus.ready) begin
      got = '{column_bus.red, column_bus.green, column_bus.blue,
              column_bus.upper_extent, column_bus.lower_extent};
      if (column_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected column request: %p", got);
      end else begin
        want = column_expected.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("column mismatch: expected %p actual %p", want, got);
        end
      end
    end
    if (long_stall_req) begin
      long_stall_req = 1'b0;
      stall_left = LONG_STALL;
    end
    if (rst) begin
      column_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      column_bus.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      column_bus.ready <= 1'b0;
    end else begin
      column_bus.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 7) == 0) recv_gap = $urandom_range(1, 11);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    frame_bus.valid = 1'b0;
    {frame_bus.low_left, frame_bus.mid_left, frame_bus.high_left, frame_bus.all_left} = '0;
    {frame_bus.low_right, frame_bus.mid_right, frame_bus.high_right} = '0;
    frame_bus.all_right = '0;
    frame_bus.column_end = 1'b0;
    column_bus.ready = 1'b0;
    {pk_low_l, pk_mid_l, pk_high_l, pk_all_l} = '0;
    {pk_low_r, pk_mid_r, pk_high_r, pk_all_r} = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed columns under reset configuration
    queue_frame(make_frame(8'd255, 8'd255, 8'd255, 1'b1));   // all levels at maximum
    queue_frame(make_frame(8'd0, 8'd0, 8'd0, 1'b1));         // all zero
    queue_frame(make_frame(8'd100, 8'd0, 8'd200, 1'b1));     // silent left channel
    queue_frame(make_frame(8'd100, 8'd200, 8'd0, 1'b1));     // silent right channel
    queue_frame(make_frame(8'd0, 8'd77, 8'd99, 1'b1));       // zero band sum
    queue_frame('{8'd255, 8'd0, 8'd0, 8'd10, 8'd255, 8'd0, 8'd0, 8'd20, 1'b0});
    queue_frame('{8'd0, 8'd0, 8'd255, 8'd30, 8'd0, 8'd0, 8'd255, 8'd40, 1'b1});
    queue_frame('{8'd0, 8'd255, 8'd0, 8'd1, 8'd0, 8'd255, 8'd0, 8'd1, 1'b1});
    queue_frame('{8'd170, 8'd85, 8'd51, 8'd204, 8'd102, 8'd153, 8'd0, 8'd255, 1'b0});
    queue_frame('{8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 1'b1});
    drain();

    // Hue extremes and out-of-range hues, extents at saturation and zero
    write_reg(CFG_BASE_HUE, 16'd359);
    write_reg(CFG_HEIGHT_SCALE, 16'hFFFF);
    write_reg(CFG_UNKNOWN_A, 16'h1234);                     // unknown index, ignored
    write_reg(CFG_UNKNOWN_B, 16'hFFFF);
    queue_frame(make_frame(8'd128, 8'd255, 8'd1, 1'b1));
    queue_frame('{8'd30, 8'd60, 8'd90, 8'd1, 8'd20, 8'd40, 8'd80, 8'd0, 1'b1});
    drain();
    write_reg(CFG_BASE_HUE, 16'hFF68);                      // 360 with high junk bits
    write_reg(CFG_HEIGHT_SCALE, 16'd0);
    queue_frame('{8'd30, 8'd60, 8'd90, 8'd200, 8'd20, 8'd40, 8'd80, 8'd100, 1'b1});
    drain();
    write_reg(CFG_BASE_HUE, 16'd511);
    write_reg(CFG_HEIGHT_SCALE, 16'd257);
    queue_frame('{8'd30, 8'd60, 8'd90, 8'd255, 8'd20, 8'd40, 8'd80, 8'd254, 1'b1});
    drain();

    // Random phases across several settings
    write_reg(CFG_BASE_HUE, 16'd60);
    write_reg(CFG_HEIGHT_SCALE, 16'd1);
    random_columns(RANDOM_FRAMES / 6);
    drain();

    write_reg(CFG_BASE_HUE, 16'd0);
    write_reg(CFG_HEIGHT_SCALE, 16'hFFFF);
    random_columns(RANDOM_FRAMES / 12);
    long_stall_req = 1'b1;                 // receiver holds off, sender keeps offering
    random_columns(RANDOM_FRAMES / 12);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      write_reg(CFG_BASE_HUE, 16'($urandom_range(0, 65535)));
      write_reg(CFG_HEIGHT_SCALE, 16'($urandom_range(0, 1023)));
      random_columns(RANDOM_FRAMES / 6);
      drain();
    end

    // Final stretch at full rate
    write_reg(CFG_BASE_HUE, 16'd300);
    write_reg(CFG_HEIGHT_SCALE, HEIGHT_SCALE_RESET);
    quiet = 1'b1;
    random_columns(RANDOM_FRAMES / 6);
    drain();

    if (mismatches == 0 && column_expected.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
hw/rtl/wcc_pkg.sv
hw/rtl/wcc_frame_if.sv
hw/rtl/wcc_column_if.sv
hw/rtl/wcc_lane.sv
hw/rtl/wcc_div.sv
hw/rtl/wcc_merge.sv
hw/rtl/waveform_column_hsv_color_unit.sv
tb/tb_top.sv
